FILE: hdl/psat_pkg.sv
// Shared types, constants and codes for the priority share table.
package psat_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_CNT_W     = 5;

  localparam int ID_W       = 22;
  localparam int PRIO_W     = 8;
  localparam int SHARE_W    = 8;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [PRIO_W-1:0]     THRESHOLD_RST = 8'd3;
  localparam logic [SHARE_W-1:0]    SHARE_MAX_RST = 8'd100;
  localparam logic [SHARE_W-1:0]    STEP_RST      = 8'd1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_MISS   = 2'd1,
    MODE_PASS   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SHARE_MAX = 2'd1,
    REG_STEP      = 2'd2,
    REG_INTERVAL  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0]     threshold;
    logic [SHARE_W-1:0]    share_max;
    logic [SHARE_W-1:0]    step;
    logic [INTERVAL_W-1:0] min_interval;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [SHARE_W-1:0] share;
    logic [TIME_W-1:0]  halve_time;
    logic [TIME_W-1:0]  raise_time;
    logic               halve_seen;
    logic               raise_seen;
  } entry_t;

endpackage

FILE: hdl/psat_entry_mem.sv
// Task table storage: one write port, one registered read port.
module psat_entry_mem #(
  parameter int DEPTH = psat_pkg::MAX_TASKS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  psat_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output psat_pkg::entry_t  rd_data
);
  import psat_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/psat_update.sv
// Per-entry update unit: eligibility, interval check, halve or clamped raise.
module psat_update (
  input  psat_pkg::cfg_t                  cfg,
  input  psat_pkg::entry_t                entry_in,
  input  logic                            is_miss,
  input  logic [psat_pkg::TIME_W-1:0]     now,
  output logic                            apply,
  output psat_pkg::entry_t                entry_out
);
  import psat_pkg::*;

  logic [TIME_W-1:0]  then_time;
  logic               seen;
  logic [TIME_W-1:0]  elapsed;
  logic               interval_ok;
  logic               eligible;
  logic [SHARE_W:0]   raised;
  logic [SHARE_W-1:0] raised_clamped;

  always_comb begin
    then_time = is_miss ? entry_in.halve_time : entry_in.raise_time;
    seen      = is_miss ? entry_in.halve_seen : entry_in.raise_seen;
    // time going backwards counts as no time elapsed
    elapsed     = (now >= then_time) ? (now - then_time) : '0;
    interval_ok = !seen || (elapsed >= TIME_W'(cfg.min_interval));
    eligible    = entry_in.prio > cfg.threshold;
    apply       = eligible && interval_ok;

    raised = {1'b0, entry_in.share} + {1'b0, cfg.step};
    raised_clamped = (raised > {1'b0, cfg.share_max}) ? cfg.share_max
                                                      : raised[SHARE_W-1:0];

    entry_out = entry_in;
    if (is_miss) begin
      entry_out.share      = entry_in.share >> 1;
      entry_out.halve_time = now;
      entry_out.halve_seen = 1'b1;
    end else begin
      entry_out.share      = raised_clamped;
      entry_out.raise_time = now;
      entry_out.raise_seen = 1'b1;
    end
  end

endmodule

FILE: hdl/priority_share_aimd_table.sv
// Top level of the priority share table with AIMD share control.
//
// Keeps up to MAX_TASKS tasks in insertion order in a single-port-write,
// registered-read table. An insert (mode 0) is written in the cycle it is
// accepted and busy stays low; a full table drops it. A miss (mode 1) or pass
// (mode 2) walks the table from entry 0, one entry per cycle through one
// shared update unit: the first entry whose id matches is the reporting task,
// and each later entry with priority above priority_threshold, up to the
// result limit, is halved (miss) or raised by increase_step up to share_max
// (pass), each kind of change rate-limited per task by min_interval_sec. An
// event holds busy until every entry has been read and its registered data
// has passed through the update unit.
// Each applied change leaves as one item on result_strobe, changed_id,
// new_share, was_halved and last, held for exactly one cycle; the receiver
// cannot stall, so items must be taken when strobed. Items of one event come
// out in table order, at most 16, and last marks the final one. Since last is
// only known once the next change is found or the walk ends, each item is
// held back until then. Mode 3 and events with unknown ids give no items.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12 and
// is to be written only while the block is idle.
module priority_share_aimd_table #(
  parameter int MAX_TASKS = psat_pkg::MAX_TASKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command side
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode,
  input  logic [psat_pkg::ID_W-1:0]            task_id,
  input  logic [psat_pkg::PRIO_W-1:0]          priority_in,
  input  logic [psat_pkg::TIME_W-1:0]          now_sec,
  // result side
  output logic                                 result_strobe,
  output logic [psat_pkg::ID_W-1:0]            changed_id,
  output logic [psat_pkg::SHARE_W-1:0]         new_share,
  output logic                                 was_halved,
  output logic                                 last,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [psat_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [psat_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [psat_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import psat_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0]     FULL_COUNT = CNT_W'(MAX_TASKS);
  localparam logic [RES_CNT_W-1:0] RES_LIMIT  = RES_CNT_W'(MAX_RESULTS);

  // configuration registers
  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  // control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   issue_idx;     // next entry to read
  logic               data_vld;      // rd_data holds entry data_idx
  logic [IDX_W-1:0]   data_idx;
  logic               found;
  logic [RES_CNT_W-1:0] res_n;

  // latched event
  logic               ev_miss;
  logic [ID_W-1:0]    ev_id;
  logic [TIME_W-1:0]  ev_now;

  // held-back item
  logic               pend_vld;
  logic [ID_W-1:0]    pend_id;
  logic [SHARE_W-1:0] pend_share;

  // table and update unit
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  entry_t             rd_data;
  entry_t             new_entry;
  logic               upd_apply;
  entry_t             upd_entry;

  logic accept, is_insert, is_event, issue_done, walk_end, match, do_apply;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= THRESHOLD_RST;
      cfg.share_max    <= SHARE_MAX_RST;
      cfg.step         <= STEP_RST;
      cfg.min_interval <= INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg.threshold    <= pwdata[PRIO_W-1:0];
        REG_SHARE_MAX: cfg.share_max    <= pwdata[SHARE_W-1:0];
        REG_STEP:      cfg.step         <= pwdata[SHARE_W-1:0];
        REG_INTERVAL:  cfg.min_interval <= pwdata[INTERVAL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(cfg.threshold);
      REG_SHARE_MAX: prdata = APB_DATA_W'(cfg.share_max);
      REG_STEP:      prdata = APB_DATA_W'(cfg.step);
      REG_INTERVAL:  prdata = APB_DATA_W'(cfg.min_interval);
    endcase
  end

  // FSM outputs
  always_comb begin
    busy       = (state != ST_IDLE);
    issue_done = (issue_idx == entry_count);
    rd_en      = (state == ST_WALK) && !issue_done;
    walk_end   = (state == ST_WALK) && issue_done && !data_vld;
  end

  assign accept    = start && !busy;
  assign is_insert = (mode_t'(mode) == MODE_INSERT);
  assign is_event  = (mode_t'(mode) == MODE_MISS) || (mode_t'(mode) == MODE_PASS);

  // FSM next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && is_event) state_next = ST_WALK;
      ST_WALK: if (walk_end) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk datapath
  assign match    = data_vld && !found && (rd_data.id == ev_id);
  assign do_apply = data_vld && found && upd_apply && (res_n < RES_LIMIT);

  always_comb begin
    new_entry.id         = task_id;
    new_entry.prio       = priority_in;
    new_entry.share      = cfg.share_max;
    new_entry.halve_time = '0;
    new_entry.raise_time = '0;
    new_entry.halve_seen = 1'b0;
    new_entry.raise_seen = 1'b0;
    if (do_apply) begin
      wr_en   = 1'b1;
      wr_addr = data_idx;
      wr_data = upd_entry;
    end else begin
      wr_en   = accept && is_insert && (entry_count < FULL_COUNT);
      wr_addr = entry_count[IDX_W-1:0];
      wr_data = new_entry;
    end
  end

  psat_entry_mem #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  psat_update u_update (
    .cfg       (cfg),
    .entry_in  (rd_data),
    .is_miss   (ev_miss),
    .now       (ev_now),
    .apply     (upd_apply),
    .entry_out (upd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      issue_idx   <= '0;
      data_vld    <= 1'b0;
      found       <= 1'b0;
      res_n       <= '0;
      pend_vld    <= 1'b0;
    end else begin
      if (wr_en && !do_apply) begin
        entry_count <= entry_count + 1'b1;
      end
      data_vld <= rd_en;
      if (accept && is_event) begin
        issue_idx <= '0;
        found     <= 1'b0;
        res_n     <= '0;
        pend_vld  <= 1'b0;
      end else begin
        if (rd_en) begin
          issue_idx <= issue_idx + 1'b1;
        end
        if (match) begin
          found <= 1'b1;
        end
        if (do_apply) begin
          res_n    <= res_n + 1'b1;
          pend_vld <= 1'b1;
        end else if (walk_end) begin
          pend_vld <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_event) begin
      ev_miss <= (mode_t'(mode) == MODE_MISS);
      ev_id   <= task_id;
      ev_now  <= now_sec;
    end
    if (rd_en) begin
      data_idx <= issue_idx[IDX_W-1:0];
    end
    if (do_apply) begin
      pend_id    <= upd_entry.id;
      pend_share <= upd_entry.share;
    end
  end

  // result items: the held item leaves when the next change appears or the
  // walk finishes, in which case it is the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= pend_vld && (do_apply || walk_end);
    end
  end

  always_ff @(posedge clk) begin
    if (pend_vld && (do_apply || walk_end)) begin
      changed_id <= pend_id;
      new_share  <= pend_share;
      was_halved <= ev_miss;
      last       <= walk_end;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_insert && entry_count == FULL_COUNT) |=> entry_count == FULL_COUNT)
    else $error("insert into full table changed count");

  a_result_in_walk: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ST_WALK))
    else $error("result outside an event walk");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    res_n <= RES_LIMIT)
    else $error("too many results for one event");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |-> state == ST_IDLE)
    else $error("last item while walk still running");
`endif

endmodule
